### hw/rtl/aabb_affine_transform_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the box transform block
// Shared checking forms used at the end of the aat_pipe module.
// ----------------------------------------------------------------------------
`ifndef AABB_AFFINE_TRANSFORM_DEFINES_SVH
`define AABB_AFFINE_TRANSFORM_DEFINES_SVH

// same-cycle implication, disabled in reset
`define AAT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define AAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/aat_pkg.sv
// ----------------------------------------------------------------------------
// aat_pkg
// Types and constants shared by the box transform block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aat_pkg;

  localparam int unsigned NumAxes   = 3;
  localparam int unsigned CoefW     = 16;
  localparam int unsigned CenterW   = 32;
  localparam int unsigned HalfW     = 31;
  localparam int unsigned RowW      = 48;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 48;
  localparam int unsigned ProdCW    = CoefW + CenterW;  // signed coef * center
  localparam int unsigned ProdHW    = CoefW + HalfW;    // |coef| * half
  localparam int unsigned SumCW     = ProdCW + 2;
  localparam int unsigned SumHW     = ProdHW + 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LIN_ROW0 = 3'd0,
    REG_LIN_ROW1 = 3'd1,
    REG_LIN_ROW2 = 3'd2,
    REG_TRANS_X  = 3'd3,
    REG_TRANS_Y  = 3'd4,
    REG_TRANS_Z  = 3'd5
  } reg_idx_t;

  localparam logic [RowW-1:0] LinRow0Rst = 48'h0000_0000_4000;
  localparam logic [RowW-1:0] LinRow1Rst = 48'h0000_4000_0000;
  localparam logic [RowW-1:0] LinRow2Rst = 48'h4000_0000_0000;

  typedef struct packed {
    logic [NumAxes-1:0][RowW-1:0]    rows;   // row i, column j at [16j+15:16j]
    logic [NumAxes-1:0][CenterW-1:0] trans;
  } xform_cfg_t;

endpackage

`default_nettype wire

### hw/rtl/aat_in_if.sv
// ----------------------------------------------------------------------------
// aat_in_if
// Box input channel: center and half-extents, valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface aat_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [aat_pkg::CenterW-1:0]  center_x;
  logic signed [aat_pkg::CenterW-1:0]  center_y;
  logic signed [aat_pkg::CenterW-1:0]  center_z;
  logic        [aat_pkg::HalfW-1:0]    half_x;
  logic        [aat_pkg::HalfW-1:0]    half_y;
  logic        [aat_pkg::HalfW-1:0]    half_z;

  modport source (output valid, center_x, center_y, center_z, half_x, half_y, half_z,
                  input ready);
  modport sink   (input valid, center_x, center_y, center_z, half_x, half_y, half_z,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/aat_out_if.sv
// ----------------------------------------------------------------------------
// aat_out_if
// Box result channel: new center and half-extents, valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface aat_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [aat_pkg::CenterW-1:0]  new_center_x;
  logic signed [aat_pkg::CenterW-1:0]  new_center_y;
  logic signed [aat_pkg::CenterW-1:0]  new_center_z;
  logic        [aat_pkg::HalfW-1:0]    new_half_x;
  logic        [aat_pkg::HalfW-1:0]    new_half_y;
  logic        [aat_pkg::HalfW-1:0]    new_half_z;

  modport source (output valid, new_center_x, new_center_y, new_center_z,
                  new_half_x, new_half_y, new_half_z, input ready);
  modport sink   (input valid, new_center_x, new_center_y, new_center_z,
                  new_half_x, new_half_y, new_half_z, output ready);
endinterface

`default_nettype wire

### hw/rtl/aat_cfg_if.sv
// ----------------------------------------------------------------------------
// aat_cfg_if
// Register write channel: index and data, valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface aat_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [aat_pkg::CfgIdxW-1:0]   index;
  logic [aat_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/aabb_affine_transform.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform
// Bounding box of an affine-transformed axis-aligned box.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   carries one box (center Q16.16, half-extents unsigned Q15.16) per item.
//   out_ch  returns one box per item: the axis-aligned bound of the eight
//           transformed corners, rounded to nearest and saturated.
//   cfg_ch  writes the matrix rows (indexes 0..2) and translation (3..5);
//           always ready. Write only while no item is in flight.
// Pipeline: three register stages; an accepted item moves through the product,
//   row-sum and output registers in turn and leaves when out_ch.ready is high.
// Throughput: one item per cycle while out_ch.ready stays high; the limit is the
//   stage-one multipliers (nine 16x32 and nine 16x31 products, one set per item).
// Reset (synchronous, rst_n low): pipeline emptied, matrix set to identity,
//   translation zero.
// Stall: when out_ch.ready is low the output register holds its item; the
//   stages behind it keep filling, and in_ch.ready drops only once all three
//   stages hold an item. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_affine_transform (
  input  wire logic clk,
  input  wire logic rst_n,
  aat_in_if.sink    in_ch,
  aat_out_if.source out_ch,
  aat_cfg_if.sink   cfg_ch
);

  aat_pkg::xform_cfg_t xform;

  aat_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .xform  (xform)
  );

  aat_pipe u_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .xform  (xform),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

### hw/rtl/aat_cfg_regs.sv
// ----------------------------------------------------------------------------
// aat_cfg_regs
// Transform registers: 3x3 Q2.14 matrix rows and Q16.16 translation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aat_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  aat_cfg_if.sink           cfg_ch,
  output aat_pkg::xform_cfg_t xform
);

  aat_pkg::xform_cfg_t cfg_r, cfg_nxt;
  logic                wr;

  assign cfg_ch.ready = 1'b1;
  assign wr           = cfg_ch.valid;
  assign xform        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (aat_pkg::reg_idx_t'(cfg_ch.index))
        aat_pkg::REG_LIN_ROW0: cfg_nxt.rows[0]  = cfg_ch.data;
        aat_pkg::REG_LIN_ROW1: cfg_nxt.rows[1]  = cfg_ch.data;
        aat_pkg::REG_LIN_ROW2: cfg_nxt.rows[2]  = cfg_ch.data;
        aat_pkg::REG_TRANS_X:  cfg_nxt.trans[0] = cfg_ch.data[aat_pkg::CenterW-1:0];
        aat_pkg::REG_TRANS_Y:  cfg_nxt.trans[1] = cfg_ch.data[aat_pkg::CenterW-1:0];
        aat_pkg::REG_TRANS_Z:  cfg_nxt.trans[2] = cfg_ch.data[aat_pkg::CenterW-1:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows[0] <= aat_pkg::LinRow0Rst;
      cfg_r.rows[1] <= aat_pkg::LinRow1Rst;
      cfg_r.rows[2] <= aat_pkg::LinRow2Rst;
      cfg_r.trans   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/aat_pipe.sv
// ----------------------------------------------------------------------------
// aat_pipe
// Three-stage datapath: products, row sums, rounding and clamping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "aabb_affine_transform_defines.svh"

module aat_pipe (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire aat_pkg::xform_cfg_t xform,
  aat_in_if.sink                   in_ch,
  aat_out_if.source                out_ch
);

  localparam int unsigned N   = aat_pkg::NumAxes;
  localparam int unsigned CW  = aat_pkg::CoefW;
  localparam int unsigned PC  = aat_pkg::ProdCW;
  localparam int unsigned PH  = aat_pkg::ProdHW;
  localparam int unsigned SC  = aat_pkg::SumCW;
  localparam int unsigned SH  = aat_pkg::SumHW;
  localparam int unsigned OC  = aat_pkg::CenterW;
  localparam int unsigned OH  = aat_pkg::HalfW;

  // Per axis the corner extremes split term by term: a*c -/+ |a|*h.
  // lo+hi = 2*S, hi-lo = 2*H, with S = t<<14 + sum a*c and H = sum |a|*h.

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  logic signed [PC-1:0] pc_r   [N][N];
  logic signed [PC-1:0] pc_nxt [N][N];
  logic        [PH-1:0] ph_r   [N][N];
  logic        [PH-1:0] ph_nxt [N][N];

  logic signed [SC-1:0] sc_r   [N];
  logic signed [SC-1:0] sc_nxt [N];
  logic        [SH-1:0] sh_r   [N];
  logic        [SH-1:0] sh_nxt [N];

  logic signed [OC-1:0] cen_r   [N];
  logic signed [OC-1:0] cen_nxt [N];
  logic        [OH-1:0] half_r   [N];
  logic        [OH-1:0] half_nxt [N];

  logic signed [OC-1:0] c_in [N];
  logic        [OH-1:0] h_in [N];

  assign en3         = !v3_r || out_ch.ready;
  assign en2         = !v2_r || en3;
  assign en1         = !v1_r || en2;
  assign in_ch.ready = en1;

  assign c_in[0] = in_ch.center_x;
  assign c_in[1] = in_ch.center_y;
  assign c_in[2] = in_ch.center_z;
  assign h_in[0] = in_ch.half_x;
  assign h_in[1] = in_ch.half_y;
  assign h_in[2] = in_ch.half_z;

  // stage 1: nine signed and nine magnitude products
  always_comb begin
    logic signed [CW-1:0] a;
    logic        [CW-1:0] a_abs;
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        a            = $signed(xform.rows[i][CW*j +: CW]);
        a_abs        = a[CW-1] ? (~a + 1'b1) : a;
        pc_nxt[i][j] = a * c_in[j];
        ph_nxt[i][j] = a_abs * h_in[j];
      end
    end
  end

  // stage 2: row sums plus translation
  always_comb begin
    logic signed [OC+14-1:0] t_sh;
    for (int i = 0; i < N; i++) begin
      t_sh      = $signed({xform.trans[i], 14'b0});
      sc_nxt[i] = SC'(pc_r[i][0]) + SC'(pc_r[i][1]) + SC'(pc_r[i][2]) + SC'(t_sh);
      sh_nxt[i] = SH'(ph_r[i][0]) + SH'(ph_r[i][1]) + SH'(ph_r[i][2]);
    end
  end

  // stage 3: round Q.30 to Q16.16 (ties up) and saturate
  always_comb begin
    logic signed [SC-1:0] rc;
    logic        [SH-1:0] rh;
    for (int i = 0; i < N; i++) begin
      rc = (sc_r[i] + SC'(8192)) >>> 14;
      rh = (sh_r[i] + SH'(8192)) >> 14;
      if (rc > SC'(signed'(64'sh7FFF_FFFF)))
        cen_nxt[i] = {1'b0, {(OC-1){1'b1}}};
      else if (rc < -SC'(signed'(64'sh8000_0000)))
        cen_nxt[i] = {1'b1, {(OC-1){1'b0}}};
      else
        cen_nxt[i] = rc[OC-1:0];
      half_nxt[i] = (|rh[SH-1:OH]) ? {OH{1'b1}} : rh[OH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pc_r <= pc_nxt;
      ph_r <= ph_nxt;
    end
    if (en2) begin
      sc_r <= sc_nxt;
      sh_r <= sh_nxt;
    end
    if (en3) begin
      cen_r  <= cen_nxt;
      half_r <= half_nxt;
    end
  end

  assign out_ch.valid        = v3_r;
  assign out_ch.new_center_x = cen_r[0];
  assign out_ch.new_center_y = cen_r[1];
  assign out_ch.new_center_z = cen_r[2];
  assign out_ch.new_half_x   = half_r[0];
  assign out_ch.new_half_y   = half_r[1];
  assign out_ch.new_half_z   = half_r[2];

  `AAT_ASSERT_NEXT(a_accept_fills_s1, in_ch.valid && in_ch.ready, v1_r)
  `AAT_ASSERT_NEXT(a_s2_moves_to_out, v2_r && en3, v3_r)
  `AAT_ASSERT_NEXT(a_s1_held_on_stall, v1_r && !en2, v1_r && $stable(sh_r[0]) == 1'b1)
  `AAT_ASSERT_SAME(a_ready_when_empty, !v1_r, in_ch.ready)

endmodule

`default_nettype wire
